[src/ttab_pkg.sv]
// ----------------------------------------------------------------------------
// ttab_pkg
// shared types, codes and sizes of the timer table
// ----------------------------------------------------------------------------
package ttab_pkg;

  localparam int TIMERS    = 16;
  localparam int MAX_FIRES = 63;
  localparam int SLOT_W    = $clog2(TIMERS);
  localparam int FIRE_W    = 6;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_CANCELED = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FIRED    = 3'd4,
    ST_DONE     = 3'd5,
    ST_REPORT   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CANCEL,
    S_SCAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] expire;
    logic [31:0] interval;
    logic [31:0] cancel_id;
    logic [47:0] now;
  } cmd_t;

  // queue side of the link between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

[src/ttab_front.sv]
// ----------------------------------------------------------------------------
// ttab_front
// accepts command words, decodes the kind and queues them for the back end
// ----------------------------------------------------------------------------
module ttab_front import ttab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [47:0] expire_ms,
  input  logic [31:0] interval_ms,
  input  logic [31:0] cancel_id,
  input  logic [47:0] now_ms,
  output qhead_t      head,
  input  logic        pop
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              do_pop;
  cmd_t              in_cmd;

  always_comb begin
    in_cmd.op        = op_t'(kind);
    in_cmd.expire    = expire_ms;
    in_cmd.interval  = interval_ms;
    in_cmd.cancel_id = cancel_id;
    in_cmd.now       = now_ms;
  end

  assign busy       = (count == (QPTR_W+1)'(QDEPTH));
  assign push       = start && !busy;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
    end
  end

  // a full queue stays full until a pop
  assert property (@(posedge clk) disable iff (rst)
    busy |=> (count == (QPTR_W+1)'(QDEPTH)) || $past(do_pop))
    else $error("queue count fell without a pop");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !head.valid)
    else $error("empty queue shows a head");
  assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("push lost");

endmodule

[src/ttab_back.sv]
// ----------------------------------------------------------------------------
// ttab_back
// slot table and the sequencer that runs add, cancel, tick and query
// ----------------------------------------------------------------------------
module ttab_back import ttab_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  qhead_t       head,
  output logic         pop,
  output logic         strobe,
  output logic [2:0]   status,
  output logic [31:0]  tmr_id,
  output logic [48:0]  next_timeout,
  output logic         more_pending,
  output logic         last
);

  logic [TIMERS-1:0] valid;
  logic [31:0]       id_mem  [TIMERS];
  logic [47:0]       exp_mem [TIMERS];
  logic [31:0]       per_mem [TIMERS];
  logic [31:0]       ord_mem [TIMERS];
  logic [31:0]       next_id;
  logic [31:0]       next_order;

  state_t            state, state_next;
  cmd_t              cur;
  logic [SLOT_W-1:0] idx;
  logic [FIRE_W-1:0] fire_cnt;

  logic              found;
  logic [SLOT_W-1:0] best_idx;
  logic [47:0]       best_exp;
  logic [31:0]       best_ord;
  logic [31:0]       best_per;
  logic [31:0]       best_id;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              idx_last;
  logic              hit;
  logic              better;
  logic              expired;
  logic              fire;
  logic [48:0]       ttn;
  logic [48:0]       reload_sum;
  logic [47:0]       reload_exp;
  logic [31:0]       id_inc;

  logic              emit;
  status_t           e_status;
  logic [31:0]       e_id;
  logic [48:0]       e_nt;
  logic              e_more;
  logic              e_last;

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMERS-1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign idx_last = (idx == SLOT_W'(TIMERS-1));
  assign hit      = valid[idx] && (id_mem[idx] == cur.cancel_id) && (cur.cancel_id != '0);
  assign better   = valid[idx] && (!found || (exp_mem[idx] < best_exp) ||
                    ((exp_mem[idx] == best_exp) && (ord_mem[idx] < best_ord)));
  assign expired  = found && (best_exp <= cur.now);
  assign fire     = (cur.op == OP_TICK) && expired && (fire_cnt != FIRE_W'(MAX_FIRES));

  always_comb begin
    if (!found) ttn = '1;
    else if (best_exp > cur.now) ttn = {1'b0, best_exp - cur.now};
    else ttn = '0;
  end

  assign reload_sum = {1'b0, best_exp} + 49'(best_per);
  assign reload_exp = reload_sum[48] ? '1 : reload_sum[47:0];
  assign id_inc     = (next_id + 32'd1 == '0) ? 32'd1 : next_id + 32'd1;
  assign pop        = (state == S_IDLE) && head.valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          case (head.cmd.op)
            OP_ADD:    state_next = S_ADD;
            OP_CANCEL: state_next = S_CANCEL;
            default:   state_next = S_SCAN;
          endcase
        end
      end
      S_ADD:    state_next = S_IDLE;
      S_CANCEL: if (hit || idx_last) state_next = S_IDLE;
      S_SCAN:   if (idx_last) state_next = S_DECIDE;
      S_DECIDE: state_next = fire ? S_SCAN : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // result words
  always_comb begin
    emit     = 1'b0;
    e_status = ST_ADDED;
    e_id     = '0;
    e_nt     = '0;
    e_more   = 1'b0;
    e_last   = 1'b1;
    case (state)
      S_ADD: begin
        emit = 1'b1;
        if (free_found) e_id = next_id;
        else e_status = ST_FULL;
      end
      S_CANCEL: begin
        if (hit) begin
          emit     = 1'b1;
          e_status = ST_CANCELED;
          e_id     = cur.cancel_id;
        end else if (idx_last) begin
          emit     = 1'b1;
          e_status = ST_NOTFOUND;
        end
      end
      S_DECIDE: begin
        emit = 1'b1;
        if (fire) begin
          e_status = ST_FIRED;
          e_id     = best_id;
          e_last   = 1'b0;
        end else begin
          e_status = (cur.op == OP_TICK) ? ST_DONE : ST_REPORT;
          e_nt     = ttn;
          e_more   = (cur.op == OP_TICK) && expired;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (state == S_ADD && free_found) begin
      id_mem[free_idx]  <= next_id;
      exp_mem[free_idx] <= cur.expire;
      per_mem[free_idx] <= cur.interval;
      ord_mem[free_idx] <= next_order;
    end else if (state == S_DECIDE && fire && best_per != '0) begin
      exp_mem[best_idx] <= reload_exp;
      ord_mem[best_idx] <= next_order;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head.cmd;
    if (state == S_SCAN && better) begin
      best_idx <= idx;
      best_exp <= exp_mem[idx];
      best_ord <= ord_mem[idx];
      best_per <= per_mem[idx];
      best_id  <= id_mem[idx];
    end
    status       <= e_status;
    tmr_id       <= e_id;
    next_timeout <= e_nt;
    more_pending <= e_more;
    last         <= e_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      next_id    <= 32'd1;
      next_order <= '0;
      idx        <= '0;
      fire_cnt   <= '0;
      found      <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      case (state)
        S_IDLE: begin
          idx      <= '0;
          found    <= 1'b0;
          fire_cnt <= '0;
        end
        S_ADD: begin
          if (free_found) begin
            valid[free_idx] <= 1'b1;
            next_id         <= id_inc;
            next_order      <= next_order + 32'd1;
          end
        end
        S_CANCEL: begin
          if (hit) valid[idx] <= 1'b0;
          idx <= idx + 1'b1;
        end
        S_SCAN: begin
          if (better) found <= 1'b1;
          idx <= idx + 1'b1;
        end
        S_DECIDE: begin
          idx   <= '0;
          found <= 1'b0;
          if (fire) begin
            fire_cnt <= fire_cnt + 1'b1;
            if (best_per != '0) next_order <= next_order + 32'd1;
            else valid[best_idx] <= 1'b0;
          end
        end
        default: idx <= '0;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FIRE_W'(MAX_FIRES))
    else $error("fire count beyond limit");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && free_found) |=> valid[$past(free_idx)])
    else $error("added slot not marked valid");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && fire) |=> state == S_SCAN && idx == '0 && !found)
    else $error("rescan not restarted after a fire");

endmodule

[src/timer_table_with_periodic_reload_top.sv]
// ----------------------------------------------------------------------------
// timer_table_with_periodic_reload_top
// software timer table with one-shot and periodic timers
// ----------------------------------------------------------------------------
// add answers from its own state, cancel scans to a hit or the end, query scans all
// a tick gives a word after each full scan, and every fire starts a new scan
// throughput is set by the sequential slot scan in the back end, one slot a cycle
// a two-word command queue lets the next command in while a scan runs
// result words appear for one cycle on strobe; the receiver cannot stall them
// synchronous reset empties the table, next id 1, order counter 0
module timer_table_with_periodic_reload_top import ttab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [47:0] expire_ms,
  input  logic [31:0] interval_ms,
  input  logic [31:0] cancel_id,
  input  logic [47:0] now_ms,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [31:0] tmr_id,
  output logic [48:0] next_timeout,
  output logic        more_pending,
  output logic        last
);

  // queue head handed from front to back
  qhead_t head;
  logic   pop;

  // front: accepts and decodes command words
  ttab_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .expire_ms   (expire_ms),
    .interval_ms (interval_ms),
    .cancel_id   (cancel_id),
    .now_ms      (now_ms),
    .head        (head),
    .pop         (pop)
  );

  // back: slot table, scans and result words
  ttab_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .status       (status),
    .tmr_id       (tmr_id),
    .next_timeout (next_timeout),
    .more_pending (more_pending),
    .last         (last)
  );

endmodule

[tb/tb_timer_table_with_periodic_reload_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_table_with_periodic_reload_top
// self-checking bench for the timer table: directed corner cases, then
// random add, cancel, tick and query words checked against a local predictor
// ----------------------------------------------------------------------------
module tb_timer_table_with_periodic_reload_top;
  import ttab_pkg::*;

  // one expected result word
  typedef struct packed {
    status_t     st;
    logic [31:0] id;
    logic [48:0] nt;
    logic        more;
    logic        lst;
  } timer_word_t;

  // predictor of the timer table plus the queue of words still owed
  class timer_scoreboard;
    bit          valid [TIMERS];
    bit [31:0]   ids [TIMERS];
    bit [47:0]   expiry [TIMERS];
    bit [31:0]   period [TIMERS];
    bit [31:0]   order [TIMERS];
    bit [31:0]   next_id;
    bit [31:0]   next_ord;
    timer_word_t owed[$];
    int          errors;

    function new();
      foreach (valid[i]) valid[i] = 0;
      next_id  = 1;
      next_ord = 0;
      errors   = 0;
    endfunction

    function void push_word(status_t st, bit [31:0] id, bit [48:0] nt, bit more,
                            bit lst);
      timer_word_t w;
      w.st = st; w.id = id; w.nt = nt; w.more = more; w.lst = lst;
      owed.push_back(w);
    endfunction

    // earliest expiry, first-inserted among ties, -1 when empty
    function int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < TIMERS; i++) begin
        if (!valid[i]) continue;
        if (best < 0 || expiry[i] < expiry[best] ||
            (expiry[i] == expiry[best] && order[i] < order[best]))
          best = i;
      end
      return best;
    endfunction

    function bit [48:0] time_to_next(bit [47:0] now);
      int e;
      e = earliest_slot();
      if (e < 0) return '1;
      if (expiry[e] > now) return {1'b0, expiry[e] - now};
      return '0;
    endfunction

    // work out the words caused by one accepted command word
    function void note_word(op_t op, bit [47:0] exp_ms, bit [31:0] ivl, bit [31:0] cid,
                            bit [47:0] now);
      int        f;
      int        e;
      int        n;
      bit        more;
      bit        hit;
      bit [48:0] sum;
      case (op)
        OP_ADD: begin
          f = -1;
          for (int i = 0; i < TIMERS; i++)
            if (!valid[i] && f < 0) f = i;
          if (f < 0) begin
            push_word(ST_FULL, 0, 0, 0, 1);
          end else begin
            valid[f]  = 1;
            ids[f]    = next_id;
            expiry[f] = exp_ms;
            period[f] = ivl;
            order[f]  = next_ord;
            next_ord++;
            push_word(ST_ADDED, next_id, 0, 0, 1);
            next_id++;
            if (next_id == 0) next_id = 1;
          end
        end
        OP_CANCEL: begin
          hit = 0;
          if (cid != 0)
            for (int i = 0; i < TIMERS; i++)
              if (!hit && valid[i] && ids[i] == cid) begin
                valid[i] = 0;
                hit = 1;
              end
          if (hit) push_word(ST_CANCELED, cid, 0, 0, 1);
          else push_word(ST_NOTFOUND, 0, 0, 0, 1);
        end
        OP_TICK: begin
          n = 0;
          more = 0;
          while (1) begin
            e = earliest_slot();
            if (e < 0 || expiry[e] > now) break;
            if (n >= MAX_FIRES) begin
              more = 1;
              break;
            end
            push_word(ST_FIRED, ids[e], 0, 0, 0);
            n++;
            if (period[e] != 0) begin
              // re-arm without drift, saturating at the top of the 48-bit range
              sum = {1'b0, expiry[e]} + {17'd0, period[e]};
              expiry[e] = sum[48] ? '1 : sum[47:0];
              order[e]  = next_ord;
              next_ord++;
            end else begin
              valid[e] = 0;
            end
          end
          push_word(ST_DONE, 0, time_to_next(now), more, 1);
        end
        default: push_word(ST_REPORT, 0, time_to_next(now), 0, 1);
      endcase
    endfunction

    function void check_word(bit [2:0] st, bit [31:0] id, bit [48:0] nt, bit more,
                             bit lst);
      timer_word_t w;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: status %0d id %0d", st, id);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (st != w.st) begin
        $error("status: expected %0d, got %0d", w.st, st); errors++;
      end
      if (id != w.id) begin
        $error("tmr_id: expected %0d, got %0d", w.id, id); errors++;
      end
      if (nt != w.nt) begin
        $error("next_timeout: expected %h, got %h", w.nt, nt); errors++;
      end
      if (more != w.more) begin
        $error("more_pending: expected %0d, got %0d", w.more, more); errors++;
      end
      if (lst != w.lst) begin
        $error("last: expected %0d, got %0d", w.lst, lst); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = '0;
  logic [47:0] expire_ms = '0;
  logic [31:0] interval_ms = '0;
  logic [31:0] cancel_id = '0;
  logic [47:0] now_ms = '0;
  logic        strobe;
  logic [2:0]  status;
  logic [31:0] tmr_id;
  logic [48:0] next_timeout;
  logic        more_pending;
  logic        last;

  timer_scoreboard sb = new();
  bit [47:0]   sim_now;      // running time of the random part
  int          word_count;
  int          idle_cycles;
  localparam int STALL_LIMIT = 4000;

  always #5 clk = ~clk;

  timer_table_with_periodic_reload_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .expire_ms(expire_ms), .interval_ms(interval_ms), .cancel_id(cancel_id),
    .now_ms(now_ms), .strobe(strobe), .status(status), .tmr_id(tmr_id),
    .next_timeout(next_timeout), .more_pending(more_pending), .last(last)
  );

  // result side: every strobed word is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && strobe)
      sb.check_word(status, tmr_id, next_timeout, more_pending, last);
  end

  // watchdog: cycles in which neither side moves a word
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one command word and hold it until accepted; start stays high
  task automatic send_word(op_t op, bit [47:0] e, bit [31:0] iv, bit [31:0] cid,
                           bit [47:0] now);
    start       <= 1'b1;
    kind        <= op;
    expire_ms   <= e;
    interval_ms <= iv;
    cancel_id   <= cid;
    now_ms      <= now;
    do @(posedge clk); while (busy);
    sb.note_word(op, e, iv, cid, now);
    word_count++;
  endtask

  // random gap on the sender side, skipped in the quiet stretch
  task automatic maybe_idle();
    if ((word_count < 110 || word_count > 170) && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // unused fields carry random bits so that every input bit toggles
  task automatic send_random_word();
    bit [47:0] e;
    bit [31:0] iv;
    bit [31:0] cid;
    bit [47:0] now;
    int        r;
    e   = {$urandom, $urandom};
    iv  = $urandom;
    cid = $urandom;
    now = {$urandom, $urandom};
    r   = $urandom_range(0, 99);
    if (r < 40) begin
      // mostly near-future timers, some one-shot, some short periods
      if ($urandom_range(0, 19) != 0) e = sim_now + $urandom_range(0, 200);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: iv = 0;
        9:          iv = $urandom;
        default:    iv = $urandom_range(1, 100);
      endcase
      send_word(OP_ADD, e, iv, cid, now);
    end else if (r < 55) begin
      case ($urandom_range(0, 9))
        0:       cid = 0;
        1:       cid = $urandom;
        default: cid = sb.next_id - $urandom_range(1, 20);
      endcase
      send_word(OP_CANCEL, e, iv, cid, now);
    end else if (r < 85) begin
      sim_now = sim_now + $urandom_range(0, 150);
      send_word(OP_TICK, e, iv, cid, sim_now);
    end else begin
      if ($urandom_range(0, 3) != 0) now = sim_now + $urandom_range(0, 50);
      send_word(OP_QUERY, e, iv, cid, now);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    word_count  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: query, tick, cancel of id 0 and of an unknown id
    send_word(OP_QUERY, '1, '1, '1, '0);
    send_word(OP_TICK, '0, '0, '0, '0);
    send_word(OP_CANCEL, '1, '1, 32'd0, '1);
    send_word(OP_CANCEL, '0, '0, 32'd5, '0);
    // field extremes, a fast periodic timer and a saturating reload
    send_word(OP_ADD, 48'd0, 32'd0, '0, '0);
    send_word(OP_ADD, '1, '1, '0, '0);
    send_word(OP_ADD, 48'd10, 32'd1, '0, '0);
    send_word(OP_TICK, '0, '0, '0, 48'd5);
    send_word(OP_QUERY, '0, '0, '0, 48'd3);
    // tick at the top of time: fire limit reached, more left pending
    send_word(OP_TICK, '0, '0, '0, '1);
    send_word(OP_CANCEL, '0, '0, 32'd2, '0);
    send_word(OP_CANCEL, '0, '0, 32'd3, '0);
    send_word(OP_QUERY, '0, '0, '0, '1);
    // fill the table with equal expiries, then one more add is refused
    for (int i = 0; i <= TIMERS; i++)
      send_word(OP_ADD, 48'd100, 32'd0, '0, '0);
    // ties fire in insertion order
    send_word(OP_TICK, '0, '0, '0, 48'd100);

    // sender holds off until the table has answered everything
    wait_drained();

    sim_now = 48'd200;
    while (word_count < 260) begin
      send_random_word();
      maybe_idle();
      if (word_count == 200) wait_drained();
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
